// File: design/l3d_pkg.sv
// ----------------------------------------------------------------------------
// l3d_pkg
// Shared types and constants for the 3D life core with the 4555 rule.
// ----------------------------------------------------------------------------
package l3d_pkg;

    localparam int CMD_W       = 2;
    localparam int POS_W       = 4;
    localparam int INTERVAL_W  = 16;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;
    localparam int CNT_W       = 5;

    localparam logic [CNT_W-1:0]      SURVIVE_LOW    = 5'd4;
    localparam logic [CNT_W-1:0]      BIRTH_COUNT    = 5'd5;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd10;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD = 2'd0,
        CMD_TICK = 2'd1,
        CMD_READ = 2'd2,
        CMD_NOP  = 2'd3
    } t_cmd;

endpackage

// File: design/l3d_ram.sv
// ----------------------------------------------------------------------------
// l3d_ram
// Generic single write, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module l3d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/life_3d_4555_step_core.sv
// ----------------------------------------------------------------------------
// life_3d_4555_step_core
// 3D cellular automaton, rule 4555, on a SIZE_X x SIZE_Y x SIZE_Z grid.
// ----------------------------------------------------------------------------
// The grid lives in two column RAMs (one word per (x,y) column, one bit per z)
// used as current and next generation; a generation flips them. After reset a
// clearing pass over all SIZE_X*SIZE_Y columns zeroes both RAMs; no beat is
// taken then. One beat is in flight at a time. A load of an interior cell
// reads its column and writes it back with the cell changed (S_LDW), a read
// of an interior cell takes the bit from its column (S_RDW); a load or read
// on the border or outside the grid, a tick without a generation and a no-op
// go straight to S_DONE. A generation tick sweeps every column: a border
// column is written with zeros, an interior column takes setup (S_GCOL),
// nine column reads through the single read port (S_GRD) and write-back
// (S_GWR). A result waits in the output register while the next beat is accepted.
// ----------------------------------------------------------------------------
module life_3d_4555_step_core #(
    parameter int SIZE_X = 16,
    parameter int SIZE_Y = 16,
    parameter int SIZE_Z = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [l3d_pkg::INTERVAL_W-1:0]      i_cfg_wdata,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [3:0] pos_x, [7:4] pos_y, [11:8] pos_z, [12] alive_in, [15:13] zero
    input  logic [l3d_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // [1:0] cmd
    input  logic [l3d_pkg::CMD_W-1:0]           i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [0] cell_out, [1] stepped, [7:2] zero
    output logic [l3d_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata
);

    localparam int XW    = $clog2(SIZE_X);
    localparam int YW    = $clog2(SIZE_Y);
    localparam int ZW    = $clog2(SIZE_Z);
    localparam int AW    = XW + YW;
    localparam int DEPTH = 1 << AW;
    localparam int CW    = l3d_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_LDW, S_RDW, S_GCOL, S_GRD, S_GWR, S_DONE
    } t_state;

    t_state r_state;

    logic [l3d_pkg::INTERVAL_W-1:0] r_interval;
    logic [l3d_pkg::INTERVAL_W-1:0] r_tick;
    logic [l3d_pkg::INTERVAL_W-1:0] n_tick;
    logic                           r_bank;
    logic [XW-1:0]                  r_cx;
    logic [YW-1:0]                  r_cy;
    logic [1:0]                     r_dx;
    logic [1:0]                     r_dy;
    logic                           r_issue;
    logic                           r_pend;
    logic                           r_pend_ctr;
    logic [CW-1:0]                  r_cnt [SIZE_Z];
    logic [CW-1:0]                  n_cnt [SIZE_Z];
    logic [SIZE_Z-1:0]              r_ctr;
    logic [ZW-1:0]                  r_z;
    logic                           r_alive;
    logic                           r_res_cell;
    logic                           r_res_step;
    logic                           r_m_valid;
    logic                           r_m_cell;
    logic                           r_m_step;

    logic [AW-1:0]     ram_raddr;
    logic [AW-1:0]     ram_waddr;
    logic [SIZE_Z-1:0] ram_wdata;
    logic              we_cur;
    logic              we_oth;
    logic              we_a;
    logic              we_b;
    logic [SIZE_Z-1:0] rd_a;
    logic [SIZE_Z-1:0] rd_b;
    logic [SIZE_Z-1:0] rd_col;
    logic [SIZE_Z-1:0] ld_col;
    logic [SIZE_Z-1:0] gen_col;

    logic [l3d_pkg::POS_W-1:0] in_x;
    logic [l3d_pkg::POS_W-1:0] in_y;
    logic [l3d_pkg::POS_W-1:0] in_z;
    logic                      in_alive;
    l3d_pkg::t_cmd             in_cmd;
    logic                      in_interior;
    logic                      s_acc;
    logic                      col_border;
    logic                      col_last;
    logic                      out_free;
    logic [XW-1:0]             nb_x;
    logic [YW-1:0]             nb_y;

    assign in_x     = i_s_axis_tdata[3:0];
    assign in_y     = i_s_axis_tdata[7:4];
    assign in_z     = i_s_axis_tdata[11:8];
    assign in_alive = i_s_axis_tdata[12];
    assign in_cmd   = l3d_pkg::t_cmd'(i_s_axis_tuser);

    assign in_interior = (int'(in_x) >= 1) && (int'(in_x) < SIZE_X - 1) &&
                         (int'(in_y) >= 1) && (int'(in_y) < SIZE_Y - 1) &&
                         (int'(in_z) >= 1) && (int'(in_z) < SIZE_Z - 1);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_m_valid || i_m_axis_tready;

    assign col_border = (r_cx == '0) || (r_cx == XW'(SIZE_X - 1)) ||
                        (r_cy == '0) || (r_cy == YW'(SIZE_Y - 1));
    assign col_last   = (r_cx == XW'(SIZE_X - 1)) && (r_cy == YW'(SIZE_Y - 1));

    assign nb_x = XW'(int'(r_cx) + int'(r_dx) - 1);
    assign nb_y = YW'(int'(r_cy) + int'(r_dy) - 1);

    assign rd_col = r_bank ? rd_b : rd_a;

    assign n_tick = ({1'b0, r_tick} + 17'd1 >= {1'b0, r_interval}) ? '0 :
                    r_tick + 16'd1;

    always_comb begin
        for (int z = 0; z < SIZE_Z; z++) begin
            n_cnt[z] = r_cnt[z] + CW'(rd_col[z] & !r_pend_ctr);
            if (z > 0) begin
                n_cnt[z] = n_cnt[z] + CW'(rd_col[z-1]);
            end
            if (z < SIZE_Z - 1) begin
                n_cnt[z] = n_cnt[z] + CW'(rd_col[z+1]);
            end
            ld_col[z]  = (ZW'(z) == r_z) ? r_alive : rd_col[z];
            gen_col[z] = (z > 0) && (z < SIZE_Z - 1) &&
                         ((r_cnt[z] == l3d_pkg::BIRTH_COUNT) ||
                          (r_ctr[z] && r_cnt[z] == l3d_pkg::SURVIVE_LOW));
        end
    end

    always_comb begin
        ram_raddr = {r_cx, r_cy};
        ram_waddr = {r_cx, r_cy};
        ram_wdata = '0;
        we_cur    = 1'b0;
        we_oth    = 1'b0;
        we_a      = 1'b0;
        we_b      = 1'b0;
        unique case (r_state)
            S_CLR: begin
                we_a = 1'b1;
                we_b = 1'b1;
            end
            S_IDLE: begin
                ram_raddr = {XW'(in_x), YW'(in_y)};
            end
            S_LDW: begin
                ram_wdata = ld_col;
                we_cur    = 1'b1;
            end
            S_GCOL: begin
                we_oth = col_border;
            end
            S_GRD: begin
                ram_raddr = {nb_x, nb_y};
            end
            S_GWR: begin
                ram_wdata = gen_col;
                we_oth    = 1'b1;
            end
            default: begin
            end
        endcase
        if (r_state != S_CLR) begin
            we_a = r_bank ? we_oth : we_cur;
            we_b = r_bank ? we_cur : we_oth;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_interval <= l3d_pkg::INTERVAL_RESET;
            r_tick     <= '0;
            r_bank     <= 1'b0;
            r_cx       <= '0;
            r_cy       <= '0;
            r_issue    <= 1'b0;
            r_pend     <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_interval <= i_cfg_wdata;
            end
            if (r_m_valid && i_m_axis_tready && (r_state != S_DONE)) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    if (col_last) begin
                        r_cx    <= '0;
                        r_cy    <= '0;
                        r_state <= S_IDLE;
                    end else if (r_cy == YW'(SIZE_Y - 1)) begin
                        r_cy <= '0;
                        r_cx <= r_cx + XW'(1);
                    end else begin
                        r_cy <= r_cy + YW'(1);
                    end
                end
                S_IDLE: begin
                    if (s_acc) begin
                        r_z        <= ZW'(in_z);
                        r_alive    <= in_alive;
                        r_res_cell <= 1'b0;
                        r_res_step <= 1'b0;
                        case (in_cmd)
                            l3d_pkg::CMD_LOAD: begin
                                if (in_interior) begin
                                    r_cx    <= XW'(in_x);
                                    r_cy    <= YW'(in_y);
                                    r_state <= S_LDW;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            l3d_pkg::CMD_READ: begin
                                if (in_interior) begin
                                    r_state <= S_RDW;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            l3d_pkg::CMD_TICK: begin
                                r_tick <= n_tick;
                                if (r_tick == '0) begin
                                    r_cx    <= '0;
                                    r_cy    <= '0;
                                    r_state <= S_GCOL;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_LDW: begin
                    r_state <= S_DONE;
                end
                S_RDW: begin
                    r_res_cell <= rd_col[r_z];
                    r_state    <= S_DONE;
                end
                S_GCOL: begin
                    if (col_border) begin
                        if (col_last) begin
                            r_bank     <= !r_bank;
                            r_res_step <= 1'b1;
                            r_state    <= S_DONE;
                        end else if (r_cy == YW'(SIZE_Y - 1)) begin
                            r_cy <= '0;
                            r_cx <= r_cx + XW'(1);
                        end else begin
                            r_cy <= r_cy + YW'(1);
                        end
                    end else begin
                        r_dx    <= 2'd0;
                        r_dy    <= 2'd0;
                        r_issue <= 1'b1;
                        for (int z = 0; z < SIZE_Z; z++) begin
                            r_cnt[z] <= '0;
                        end
                        r_state <= S_GRD;
                    end
                end
                S_GRD: begin
                    r_pend     <= r_issue;
                    r_pend_ctr <= (r_dx == 2'd1) && (r_dy == 2'd1);
                    if (r_issue) begin
                        if (r_dy == 2'd2) begin
                            r_dy <= 2'd0;
                            r_dx <= r_dx + 2'd1;
                            if (r_dx == 2'd2) begin
                                r_issue <= 1'b0;
                            end
                        end else begin
                            r_dy <= r_dy + 2'd1;
                        end
                    end
                    if (r_pend) begin
                        r_cnt <= n_cnt;
                        if (r_pend_ctr) begin
                            r_ctr <= rd_col;
                        end
                        if (!r_issue) begin
                            r_state <= S_GWR;
                        end
                    end
                end
                S_GWR: begin
                    if (col_last) begin
                        r_bank     <= !r_bank;
                        r_res_step <= 1'b1;
                        r_state    <= S_DONE;
                    end else begin
                        if (r_cy == YW'(SIZE_Y - 1)) begin
                            r_cy <= '0;
                            r_cx <= r_cx + XW'(1);
                        end else begin
                            r_cy <= r_cy + YW'(1);
                        end
                        r_state <= S_GCOL;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_cell  <= r_res_cell;
                        r_m_step  <= r_res_step;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    l3d_ram #(
        .WIDTH (SIZE_Z),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_a)
    );

    l3d_ram #(
        .WIDTH (SIZE_Z),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_b)
    );

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {6'd0, r_m_step, r_m_cell};

`ifndef SYNTHESIS
    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[0] && o_m_axis_tdata[1]))
        else $error("read and generation flags set together");

    a_dual_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (we_a && we_b) |-> (r_state == S_CLR))
        else $error("both grid banks written outside clearing pass");

    a_bank_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_bank != $past(r_bank))) |-> (r_state == S_DONE && r_res_step))
        else $error("bank flip without a finished generation");
`endif

endmodule
